// ===== hw/rtl/fpexp_pkg.sv =====
// Package for the Q17.15 exponential pipeline: widths, constants, the e^n tables,
// the Taylor coefficients and the side-band type carried along the pipeline.
// No dependencies.
`default_nettype none

package fpexp_pkg;

  localparam int TabSize  = 12;
  localparam int Terms    = 9;
  localparam int TayStg   = Terms - 1;
  localparam int DivSteps = 30;

  localparam logic [30:0] ExpSat = 31'h7FFF_FFFF;
  localparam logic [30:0] ExpOne = 31'h0000_8000;
  localparam logic [15:0] RndQ15 = 16'h4000;
  localparam logic [15:0] PolyOfs = 16'h7FFF;

  typedef struct packed {
    logic        neg;
    logic        fix;
    logic [30:0] fix_val;
  } side_t;

  function automatic logic [15:0] exp_int(input logic [3:0] idx);
    logic [15:0] v;
    unique case (idx)
      4'd0:    v = 16'h0001;
      4'd1:    v = 16'h0002;
      4'd2:    v = 16'h0007;
      4'd3:    v = 16'h0014;
      4'd4:    v = 16'h0036;
      4'd5:    v = 16'h0094;
      4'd6:    v = 16'h0193;
      4'd7:    v = 16'h0448;
      4'd8:    v = 16'h0BA4;
      4'd9:    v = 16'h1FA7;
      4'd10:   v = 16'h560A;
      4'd11:   v = 16'hE9E2;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] exp_frac(input logic [3:0] idx);
    logic [15:0] v;
    unique case (idx)
      4'd0:    v = 16'h0000;
      4'd1:    v = 16'h5BF1;
      4'd2:    v = 16'h31CD;
      4'd3:    v = 16'h0AF3;
      4'd4:    v = 16'h4C90;
      4'd5:    v = 16'h34E2;
      4'd6:    v = 16'h36E3;
      4'd7:    v = 16'h510B;
      4'd8:    v = 16'h7A9F;
      4'd9:    v = 16'h0ABE;
      4'd10:   v = 16'h3B9F;
      4'd11:   v = 16'h1224;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] taylor_coef(input logic [3:0] idx);
    logic [15:0] v;
    unique case (idx)
      4'd0:    v = 16'h7FFF;
      4'd1:    v = 16'h7FFF;
      4'd2:    v = 16'h4000;
      4'd3:    v = 16'h1555;
      4'd4:    v = 16'h0555;
      4'd5:    v = 16'h0111;
      4'd6:    v = 16'h002E;
      4'd7:    v = 16'h0007;
      4'd8:    v = 16'h0001;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fixed_point_exp_q17_15.sv =====
// Pipelined e^x for a signed Q17.15 exponent, unsigned Q16.15 result.
// Depends on fpexp_pkg (tables, coefficients, side-band type).
//
//   channel | signals                                  | direction
//   arg     | arg_valid, arg_stall, exponent_q15[31:0] | into the block
//   res     | res_valid, res_stall, exp_value_q15[30:0] | out of the block
//
// One transaction enters per cycle unless a stalled result holds the pipeline.
// The depth comes from eight Taylor stages and a 30-stage restoring divider.
// Reset (rst, synchronous) clears all valid bits.
// A stalled result holds the whole pipeline, and arg_stall follows it.
`default_nettype none

module fixed_point_exp_q17_15 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        arg_valid,
  output logic             arg_stall,
  input  wire logic [31:0] exponent_q15,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [30:0]      exp_value_q15
);

  localparam int NT = fpexp_pkg::TayStg;
  localparam int ND = fpexp_pkg::DivSteps;

  logic adv;

  logic        in_neg;
  logic [31:0] in_mag;
  logic [17:0] in_n;
  logic        in_sat;
  logic        in_zero;
  fpexp_pkg::side_t in_side;

  logic                      t_v    [0:NT];
  fpexp_pkg::side_t          t_side [0:NT];
  logic [3:0]                t_n    [0:NT];
  logic signed [15:0]        t_f    [0:NT];
  logic signed [15:0]        t_z    [0:NT];
  logic signed [33:0]        t_acc  [0:NT];

  logic signed [31:0]        zf_prod [1:NT];
  logic signed [32:0]        zc_prod [1:NT];
  logic signed [32:0]        zf_rnd  [1:NT];

  logic               p_v;
  fpexp_pkg::side_t   p_side;
  logic [3:0]         p_n;
  logic [15:0]        p_poly;
  logic signed [33:0] poly_sum;

  logic               m_v;
  fpexp_pkg::side_t   m_side;
  logic [31:0]        m_fr;
  logic [31:0]        m_in;

  logic [32:0]        prod;
  fpexp_pkg::side_t   r_side_next;

  logic               d_v    [0:ND];
  fpexp_pkg::side_t   d_side [0:ND];
  logic [32:0]        d_div  [0:ND];
  logic [32:0]        d_rem  [0:ND];
  logic [ND-1:0]      d_q    [0:ND];

  logic [33:0]        d_sh   [1:ND];
  logic               d_ge   [1:ND];
  logic [32:0]        d_rem_next [1:ND];

  assign adv       = !(res_valid && res_stall);
  assign arg_stall = !adv;

  always_comb begin
    in_neg  = exponent_q15[31];
    in_mag  = in_neg ? (32'd0 - exponent_q15) : exponent_q15;
    in_n    = {1'b0, in_mag[31:15]} + {17'd0, in_mag[14]};
    in_sat  = in_n >= 18'(fpexp_pkg::TabSize);
    in_zero = exponent_q15 == 32'd0;
    in_side.neg     = in_neg;
    in_side.fix     = in_zero || in_sat;
    in_side.fix_val = in_zero ? fpexp_pkg::ExpOne : (in_neg ? 31'd0 : fpexp_pkg::ExpSat);
  end

  always_comb begin
    for (int k = 1; k <= NT; k++) begin
      zf_prod[k] = t_z[k-1] * t_f[k-1];
      zc_prod[k] = t_z[k-1] * $signed({1'b0, fpexp_pkg::taylor_coef(4'(k))});
      zf_rnd[k]  = (33'(zf_prod[k]) + 33'(fpexp_pkg::RndQ15)) >>> 15;
    end
  end

  always_comb begin
    poly_sum = ((t_acc[NT] + 34'(fpexp_pkg::RndQ15)) >>> 15) + 34'(fpexp_pkg::PolyOfs);
  end

  always_comb begin
    prod = 33'((m_fr + 32'(fpexp_pkg::RndQ15)) >> 15) + {1'b0, m_in};
    r_side_next = m_side;
    if (!m_side.fix) begin
      if (!m_side.neg) begin
        r_side_next.fix     = 1'b1;
        r_side_next.fix_val = (prod > 33'(fpexp_pkg::ExpSat)) ? fpexp_pkg::ExpSat : prod[30:0];
      end else if (prod == 33'd0) begin
        r_side_next.fix     = 1'b1;
        r_side_next.fix_val = 31'd0;
      end
    end
  end

  always_comb begin
    for (int j = 1; j <= ND; j++) begin
      d_sh[j]       = {d_rem[j-1], 1'b1};
      d_ge[j]       = d_sh[j] >= {1'b0, d_div[j-1]};
      d_rem_next[j] = d_ge[j] ? 33'(d_sh[j] - {1'b0, d_div[j-1]}) : d_sh[j][32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NT; k++) t_v[k] <= 1'b0;
      p_v <= 1'b0;
      m_v <= 1'b0;
      for (int j = 0; j <= ND; j++) d_v[j] <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      t_v[0] <= arg_valid;
      for (int k = 1; k <= NT; k++) t_v[k] <= t_v[k-1];
      p_v <= t_v[NT];
      m_v <= p_v;
      d_v[0] <= m_v;
      for (int j = 1; j <= ND; j++) d_v[j] <= d_v[j-1];
      res_valid <= d_v[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_side[0] <= in_side;
      t_n[0]    <= in_n[3:0];
      t_f[0]    <= $signed({in_mag[14], in_mag[14:0]});
      t_z[0]    <= $signed({in_mag[14], in_mag[14:0]});
      t_acc[0]  <= 34'sd0;
      for (int k = 1; k <= NT; k++) begin
        t_side[k] <= t_side[k-1];
        t_n[k]    <= t_n[k-1];
        t_f[k]    <= t_f[k-1];
        t_z[k]    <= zf_rnd[k][15:0];
        t_acc[k]  <= t_acc[k-1] + 34'(zc_prod[k]);
      end
      p_side <= t_side[NT];
      p_n    <= t_n[NT];
      p_poly <= poly_sum[15:0];
      m_side <= p_side;
      m_fr   <= p_poly * fpexp_pkg::exp_frac(p_n);
      m_in   <= p_poly * fpexp_pkg::exp_int(p_n);
      d_side[0] <= r_side_next;
      d_div[0]  <= prod;
      d_rem[0]  <= 33'd0;
      d_q[0]    <= '0;
      for (int j = 1; j <= ND; j++) begin
        d_side[j] <= d_side[j-1];
        d_div[j]  <= d_div[j-1];
        d_rem[j]  <= d_rem_next[j];
        d_q[j]    <= {d_q[j-1][ND-2:0], d_ge[j]};
      end
      exp_value_q15 <= d_side[ND].fix ? d_side[ND].fix_val : 31'(d_q[ND]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpexp_chk.sv =====
// Port-level checker for the exponential pipeline, bound to the top level.
// Depends only on the ports of fixed_point_exp_q17_15.
`default_nettype none

module fpexp_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        arg_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [30:0] exp_value_q15
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(exp_value_q15))
    else $error("Stalled result changed or vanished.");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    arg_stall == (res_valid && res_stall))
    else $error("Input stall does not follow the held output.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("Result valid right after reset.");

  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !arg_stall)
    else $error("Input stalled while the output is empty.");

endmodule

bind fixed_point_exp_q17_15 fpexp_chk u_fpexp_chk (
  .clk(clk),
  .rst(rst),
  .arg_stall(arg_stall),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .exp_value_q15(exp_value_q15)
);

`default_nettype wire
